// ----- src/assert_macros.svh -----
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock outside reset
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CDQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- src/cdq_pkg.sv -----
`default_nettype none

package cdq_pkg;

  // fixed field widths
  localparam int OUT_W = 32;
  localparam int CAP_W = 4;

  // defaults for the top level parameters
  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // operation codes
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // input request
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] push_value;
  } req_t;

  // result
  typedef struct packed {
    logic signed [31:0] popped_value;
    status_t            status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [CAP_W-1:0]   entry_count;
    logic               is_empty;
    logic               is_full;
  } res_t;

endpackage

`default_nettype wire

// ----- src/circular_deque_top.sv -----
// channel   dir   handshake               payload
// cfg       in    cfg_we                  cfg_wdata (capacity)
// in        in    in_valid / in_stall     in_data   (req_t)
// out       out   out_valid / out_stall   out_data  (res_t)
//
// One request per cycle while in_stall is low; a result is registered after its request is taken
// (request register, then result register), and the front-ordered and rear-ordered entry
// registers are updated together with the result register.
// Reset (synchronous) empties the deque and sets the capacity to 8, clamped to the depth.
// out_stall holds the result register; in_stall rises only when both registers are full and out_stall is high.
`default_nettype none

`include "assert_macros.svh"

module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire req_t             in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      res_t             out_data
);

  // usable entries: the capacity field cannot name more than its maximum
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam int SLOTS   = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam logic [CAP_W-1:0] CAP_TOP = CAP_W'(SLOTS);

  // capacity in use, clamped to 1..SLOTS
  function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    priority if (c == '0) begin
      r = CAP_W'(1);
    end else if (c > CAP_TOP) begin
      r = CAP_TOP;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // entries kept twice: fq has the front at slot 0, rq has the rear at slot 0
  logic [DATA_WIDTH-1:0] fq      [SLOTS];
  logic [DATA_WIDTH-1:0] rq      [SLOTS];
  logic [DATA_WIDTH-1:0] fq_next [SLOTS];
  logic [DATA_WIDTH-1:0] rq_next [SLOTS];

  logic [CAP_W-1:0] count;
  logic [CAP_W-1:0] count_next;
  logic [CAP_W-1:0] cap_use;

  logic  req_valid;
  req_t  req;
  logic  out_free;
  logic  in_take;
  logic  go;
  res_t  res_next;

  status_t               status_next;
  logic [DATA_WIDTH-1:0] push_dw;
  logic [DATA_WIDTH-1:0] popped_raw;
  logic [DATA_WIDTH-1:0] front_raw;
  logic [DATA_WIDTH-1:0] rear_raw;
  logic [OUT_W-1:0]      popped_ext;
  logic [OUT_W-1:0]      front_ext;
  logic [OUT_W-1:0]      rear_ext;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign go       = req_valid && out_free;
  assign in_stall = req_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // request value into stored width (zero fill above 32 bits)
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_push
    if (g < OUT_W) begin : g_bit
      assign push_dw[g] = req.push_value[g];
    end else begin : g_zero
      assign push_dw[g] = 1'b0;
    end
  end

  // stored values out to 32 bits, sign-extended
  for (genvar g = 0; g < OUT_W; g++) begin : g_ext
    if (g < DATA_WIDTH) begin : g_bit
      assign popped_ext[g] = popped_raw[g];
      assign front_ext[g]  = front_raw[g];
      assign rear_ext[g]   = rear_raw[g];
    end else begin : g_sign
      assign popped_ext[g] = popped_raw[DATA_WIDTH-1];
      assign front_ext[g]  = front_raw[DATA_WIDTH-1];
      assign rear_ext[g]   = rear_raw[DATA_WIDTH-1];
    end
  end

  // deque update for the registered request
  always_comb begin
    fq_next     = fq;
    rq_next     = rq;
    count_next  = count;
    popped_raw  = '0;
    status_next = ST_DONE;
    unique case (req.cmd)
      CMD_PUSH_FRONT: begin
        if (count >= cap_use) begin
          status_next = ST_FULL;
        end else begin
          fq_next[0] = push_dw;
          for (int i = 1; i < SLOTS; i++) begin
            fq_next[i] = fq[i-1];
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (count == CAP_W'(i)) begin
              rq_next[i] = push_dw;
            end
          end
          count_next = count + CAP_W'(1);
        end
      end
      CMD_PUSH_REAR: begin
        if (count >= cap_use) begin
          status_next = ST_FULL;
        end else begin
          rq_next[0] = push_dw;
          for (int i = 1; i < SLOTS; i++) begin
            rq_next[i] = rq[i-1];
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (count == CAP_W'(i)) begin
              fq_next[i] = push_dw;
            end
          end
          count_next = count + CAP_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          popped_raw = fq[0];
          for (int i = 0; i < SLOTS - 1; i++) begin
            fq_next[i] = fq[i+1];
          end
          count_next = count - CAP_W'(1);
        end
      end
      CMD_POP_REAR: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          popped_raw = rq[0];
          for (int i = 0; i < SLOTS - 1; i++) begin
            rq_next[i] = rq[i+1];
          end
          count_next = count - CAP_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // end values after the update, zero when empty
  assign front_raw = (count_next == '0) ? '0 : fq_next[0];
  assign rear_raw  = (count_next == '0) ? '0 : rq_next[0];

  // result fields
  always_comb begin
    res_next.popped_value = popped_ext;
    res_next.status       = status_next;
    res_next.front_value  = front_ext;
    res_next.rear_value   = rear_ext;
    res_next.entry_count  = count_next;
    res_next.is_empty     = (count_next == '0);
    res_next.is_full      = (count_next >= cap_use);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      cap_use   <= cap_clamp(CAP_RESET);
    end else begin
      if (in_take) begin
        req_valid <= 1'b1;
      end else if (out_free) begin
        req_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        cap_use <= cap_clamp(cfg_wdata);
        count   <= '0;
      end else if (go) begin
        count <= count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= in_data;
    end
    if (go) begin
      out_data <= res_next;
      fq       <= fq_next;
      rq       <= rq_next;
    end
  end

  // checks
  `CDQ_NEVER(a_count_cap, count > cap_use, "held count above capacity in use")
  `CDQ_ASSERT(a_result_follows, go |=> out_valid, "request consumed without a result")
  `CDQ_ASSERT(a_result_count, go |=> (out_data.entry_count == count), "result count differs")
  `CDQ_ASSERT(a_empty, out_valid |-> (out_data.is_empty == ~|out_data.entry_count), "empty flag")

endmodule

`default_nettype wire

// ----- tb/circular_deque_checker.sv -----
`timescale 1ns / 100ps

module circular_deque_checker
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  req_t             in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  res_t             out_data,
  output int               mismatches,
  output int               pending
);

  localparam int IDX_W      = $clog2(DEPTH_DEF);
  localparam int PRINT_MAX  = 100;

  // shadow copy of the deque
  logic signed [31:0] ring_copy [DEPTH_DEF];
  logic [IDX_W-1:0]   head_pos;
  logic [IDX_W-1:0]   tail_pos;
  logic [CAP_W-1:0]   held;
  logic [CAP_W-1:0]   cap_setting;

  // results predicted for requests already taken, oldest first
  res_t predicted_results [$];

  // capacity actually used by the ring
  function automatic int cap_in_effect();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH_DEF) return DEPTH_DEF;
    return int'(cap_setting);
  endfunction

  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i, input int cap);
    return (int'(i) + 1 >= cap) ? '0 : IDX_W'(int'(i) + 1);
  endfunction

  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i, input int cap);
    return (i == 0 || int'(i) >= cap) ? IDX_W'(cap - 1) : IDX_W'(int'(i) - 1);
  endfunction

  // apply one request to the shadow deque and build the result it should give
  function automatic res_t apply_deque_op(input req_t r);
    res_t o;
    int cap;
    o = '0;
    cap = cap_in_effect();
    o.status = ST_DONE;
    if (r.cmd == CMD_PUSH_FRONT || r.cmd == CMD_PUSH_REAR) begin
      if (held >= cap) begin
        o.status = ST_FULL;
      end else begin
        if (held == 0) begin
          head_pos = '0;
          tail_pos = '0;
          ring_copy[0] = r.push_value;
        end else if (r.cmd == CMD_PUSH_FRONT) begin
          head_pos = step_back(head_pos, cap);
          ring_copy[head_pos] = r.push_value;
        end else begin
          tail_pos = step_fwd(tail_pos, cap);
          ring_copy[tail_pos] = r.push_value;
        end
        held = held + 1'b1;
      end
    end else if (held == 0) begin
      o.status = ST_EMPTY;
    end else begin
      if (r.cmd == CMD_POP_FRONT) begin
        o.popped_value = ring_copy[head_pos];
        head_pos = step_fwd(head_pos, cap);
      end else begin
        o.popped_value = ring_copy[tail_pos];
        tail_pos = step_back(tail_pos, cap);
      end
      held = held - 1'b1;
      // last entry gone: both ends go back to slot zero
      if (held == 0) begin
        head_pos = '0;
        tail_pos = '0;
      end
    end
    if (held != 0) begin
      o.front_value = ring_copy[head_pos];
      o.rear_value  = ring_copy[tail_pos];
    end
    o.entry_count = held;
    o.is_empty    = (held == 0);
    o.is_full     = (held >= cap);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_MAX)
      $display("[%0t] mismatch on %s: got %0h, predicted %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      predicted_results.delete();
      foreach (ring_copy[k]) ring_copy[k] = '0;
      head_pos    = '0;
      tail_pos    = '0;
      held        = '0;
      cap_setting = CAP_RESET;
      mismatches  = 0;
    end else begin
      // compare a taken result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request waiting", 32'(out_data.entry_count), '0);
        end else begin
          want = predicted_results.pop_front();
          check_field("popped_value", out_data.popped_value, want.popped_value);
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("front_value", out_data.front_value, want.front_value);
          check_field("rear_value", out_data.rear_value, want.rear_value);
          check_field("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
          check_field("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
          check_field("is_full", 32'(out_data.is_full), 32'(want.is_full));
        end
      end
      // capacity write also empties the deque
      if (cfg_we) begin
        cap_setting = cfg_wdata;
        head_pos    = '0;
        tail_pos    = '0;
        held        = '0;
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(apply_deque_op(in_data));
    end
    pending = predicted_results.size();
  end

endmodule

// ----- tb/circular_deque_top_tb.sv -----
`timescale 1ns / 100ps

module circular_deque_top_tb;
  import cdq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int SEGMENT      = 30;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 10;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = CAP_RESET;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  res_t             out_data;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  circular_deque_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  circular_deque_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // stop if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[circular_deque_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each result is taken
  always begin : result_sink
    int hold;
    hold = calm ? 0 : $urandom_range(0, 10);
    if (hold > 0) begin
      @(negedge clk);
      out_stall <= 1'b1;
      repeat (hold) @(negedge clk);
      out_stall <= 1'b0;
    end
    @(posedge clk);
    while (!(out_valid && !out_stall)) @(posedge clk);
  end

  // drive one request after a random gap; called and returns at a falling edge
  task automatic send_request(input cmd_t op, input logic signed [31:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{cmd: op, push_value: val};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // push data with the extremes showing up often
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int fixed_caps [6];
    int push_bias;
    cmd_t op;
    fixed_caps = '{1, 8, 0, 15, 2, 5};
    push_bias = 50;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pops, extremes at both ends, last-entry pop
    send_request(CMD_POP_FRONT, $urandom);
    send_request(CMD_POP_REAR, $urandom);
    send_request(CMD_PUSH_FRONT, 32'sh7fffffff);
    send_request(CMD_PUSH_REAR, 32'sh80000000);
    send_request(CMD_PUSH_FRONT, '1);
    send_request(CMD_PUSH_REAR, '0);
    send_request(CMD_POP_FRONT, $urandom);
    send_request(CMD_POP_REAR, $urandom);
    send_request(CMD_POP_REAR, $urandom);
    send_request(CMD_POP_FRONT, $urandom);

    // small ring: fill, refused pushes, drain, refill
    set_capacity(2);
    send_request(CMD_PUSH_REAR, $urandom);
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_PUSH_REAR, $urandom);
    send_request(CMD_POP_REAR, $urandom);
    send_request(CMD_POP_FRONT, $urandom);
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_PUSH_REAR, $urandom);

    // zero acts as one; the write drops the two held entries
    set_capacity(0);
    send_request(CMD_POP_FRONT, $urandom);
    send_request(CMD_PUSH_REAR, $urandom);
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_POP_REAR, $urandom);
    send_request(CMD_POP_REAR, $urandom);

    // random phases, each with its own capacity
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(p < 6 ? CAP_W'(fixed_caps[p]) : CAP_W'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // new segment: fill-heavy, drain-heavy or balanced, calm or not
        if (n % SEGMENT == 0) begin
          case ($urandom_range(0, 2))
            0:       push_bias = 85;
            1:       push_bias = 15;
            default: push_bias = 50;
          endcase
          calm = ($urandom_range(0, 3) == 0);
        end
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(0, 99) < push_bias)
          op = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
        send_request(op, pick_value());
      end
    end

    // wait for the last results, then a short tail
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[circular_deque_top] OK");
    else
      $display("[circular_deque_top] ERROR");
    $finish;
  end

endmodule
